/* rtl/positional_ordered_list_macros.svh */
// Assertion helpers used by the checker file pol_checker.sv.
`ifndef POSITIONAL_ORDERED_LIST_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_MACROS_SVH

// The consequent is checked on the same clock edge.
`define POL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent is checked on the following clock edge.
`define POL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pol_pkg.sv */
package pol_pkg;

    localparam int unsigned DEPTH     = 64;
    localparam int unsigned ID_WIDTH  = 16;
    localparam int unsigned AW        = $clog2(DEPTH);
    localparam int unsigned CW        = $clog2(DEPTH + 1);
    localparam int unsigned POS_W     = 8;
    localparam int unsigned SONG_W    = 16;
    localparam int unsigned CNT_OUT_W = 7;

    typedef enum logic [1:0] {
        KIND_INSERT   = 2'd0,
        KIND_REMOVE   = 2'd1,
        KIND_READ     = 2'd2,
        KIND_CONTAINS = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_kind                     kind;
        logic signed [POS_W-1:0]   position;
        logic        [SONG_W-1:0]  song_id;
    } t_in;

    typedef struct packed {
        logic [SONG_W-1:0]    item_value;
        logic                 hit;
        logic [CNT_OUT_W-1:0] item_count;
        t_status              status;
    } t_out;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic busy;
    } t_sts;

endpackage

/* rtl/positional_ordered_list.sv */
// Channel   Direction  Valid        Stall        Word
// command   in         i_in_valid   o_in_stall   i_in_word  (kind, position, song_id)
// result    out        o_out_valid  i_out_stall  o_out_word (item_value, hit, item_count, status)
//
// One command is worked on at a time. With n entries moved (insert, remove) or scanned (read,
// contains), one a cycle, a command goes from the idle state through the loop state to the finish
// state, which waits while a stalled result holds the output; n is zero for a rejected command,
// an insert at the tail or a remove of the last. The entry memory has a single write port; a read
// scans one entry. The next command can be accepted in the cycle the result is presented, even
// under stall. Reset is synchronous and clears the item count; the entry memory is not cleared.

module positional_ordered_list (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pol_pkg::t_in  i_in_word,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output pol_pkg::t_out o_out_word
);

    pol_pkg::t_cmd cmd;
    pol_pkg::t_sts sts;

    pol_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pol_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_word  (i_in_word),
        .o_sts      (sts),
        .o_out_word (o_out_word)
    );

endmodule

/* rtl/pol_ram.sv */
module pol_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pol_ctrl.sv */
module pol_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  pol_pkg::t_sts i_sts,
    output pol_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOP,
        S_FIN
    } t_state;

    t_state r_state;
    logic   r_ovalid;
    logic   slot_free;

    assign slot_free    = !r_ovalid || !i_out_stall;
    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_ovalid;
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.step   = (r_state == S_LOOP);
    assign o_cmd.finish = (r_state == S_FIN) && slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (o_cmd.finish) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_LOOP;
                    end
                end
                S_LOOP: begin
                    if (!i_sts.busy) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/pol_datapath.sv */
module pol_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pol_pkg::t_cmd i_cmd,
    input  pol_pkg::t_in  i_in_word,
    output pol_pkg::t_sts o_sts,
    output pol_pkg::t_out o_out_word
);

    localparam int unsigned AW   = pol_pkg::AW;
    localparam int unsigned CW   = pol_pkg::CW;
    localparam int unsigned IW   = pol_pkg::ID_WIDTH;
    localparam int unsigned CMPW = ((CW > pol_pkg::POS_W) ? CW : pol_pkg::POS_W) + 1;

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    pol_pkg::t_kind     r_kind;
    logic [IW-1:0]      r_id;
    logic [AW-1:0]      r_at;
    logic [AW-1:0]      r_ptr;
    logic [CW-1:0]      r_left;
    logic               r_pend;
    logic [AW-1:0]      r_wr_addr;
    logic [IW-1:0]      r_val;
    logic               r_hit;
    pol_pkg::t_status   r_status;
    pol_pkg::t_out      r_out;

    logic signed [CMPW-1:0] s_pos;
    logic signed [CMPW-1:0] s_cnt;
    logic signed [CMPW-1:0] pos_m1;
    logic                   list_empty;
    logic                   list_full;
    logic [AW-1:0]          ins_at;
    logic [AW-1:0]          rem_at;
    logic                   ok_finish;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [IW-1:0] ram_wdata;
    logic          ram_re;
    logic [IW-1:0] ram_rdata;

    assign s_pos      = CMPW'($signed(i_in_word.position));
    assign s_cnt      = $signed(CMPW'(r_count));
    assign pos_m1     = s_pos - CMPW'(1);
    assign list_empty = (r_count == '0);
    assign list_full  = (r_count == CW'(pol_pkg::DEPTH));

    // Insert clamps to 0..count; remove and read clamp to 1..count and go zero-based.
    assign ins_at = (s_pos < 0)     ? '0 :
                    (s_pos > s_cnt) ? r_count[AW-1:0] : s_pos[AW-1:0];
    assign rem_at = (s_pos <= 0)    ? '0 :
                    (s_pos > s_cnt) ? AW'(r_count - CW'(1)) : pos_m1[AW-1:0];

    assign ok_finish = i_cmd.finish && (r_status == pol_pkg::ST_OK);

    always_comb begin
        n_count = r_count;
        if (ok_finish && (r_kind == pol_pkg::KIND_INSERT)) begin
            n_count = r_count + CW'(1);
        end else if (ok_finish && (r_kind == pol_pkg::KIND_REMOVE)) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_left  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.load) begin
                r_kind <= i_in_word.kind;
                r_id   <= i_in_word.song_id[IW-1:0];
                r_val  <= '0;
                r_hit  <= 1'b0;
                r_pend <= 1'b0;
                case (i_in_word.kind)
                    pol_pkg::KIND_INSERT: begin
                        if (list_full) begin
                            r_status <= pol_pkg::ST_FULL;
                            r_left   <= '0;
                        end else begin
                            r_status <= pol_pkg::ST_OK;
                            r_at     <= ins_at;
                            r_ptr    <= AW'(r_count - CW'(1));
                            r_left   <= r_count - CW'(ins_at);
                        end
                    end
                    default: begin
                        if (list_empty) begin
                            r_status <= pol_pkg::ST_EMPTY;
                            r_left   <= '0;
                        end else begin
                            r_status <= pol_pkg::ST_OK;
                            r_at     <= rem_at;
                            case (i_in_word.kind)
                                pol_pkg::KIND_REMOVE: begin
                                    r_ptr  <= AW'(CW'(rem_at) + CW'(1));
                                    r_left <= r_count - CW'(1) - CW'(rem_at);
                                end
                                pol_pkg::KIND_READ: begin
                                    r_ptr  <= rem_at;
                                    r_left <= CW'(1);
                                end
                                default: begin
                                    r_ptr  <= '0;
                                    r_left <= r_count;
                                end
                            endcase
                        end
                    end
                endcase
            end else begin
                if (i_cmd.step) begin
                    r_pend <= (r_left != '0);
                    if (r_left != '0) begin
                        r_left <= r_left - CW'(1);
                        if (r_kind == pol_pkg::KIND_INSERT) begin
                            r_ptr     <= r_ptr - AW'(1);
                            r_wr_addr <= r_ptr + AW'(1);
                        end else begin
                            r_ptr     <= r_ptr + AW'(1);
                            r_wr_addr <= r_ptr - AW'(1);
                        end
                    end
                end
                if (r_pend) begin
                    if (r_kind == pol_pkg::KIND_READ) begin
                        r_val <= ram_rdata;
                        r_hit <= 1'b1;
                    end else if ((r_kind == pol_pkg::KIND_CONTAINS) && (ram_rdata == r_id)) begin
                        r_hit <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.item_value <= pol_pkg::SONG_W'(r_val);
            r_out.hit        <= r_hit;
            r_out.item_count <= pol_pkg::CNT_OUT_W'(n_count);
            r_out.status     <= r_status;
        end
    end

    assign ram_re    = i_cmd.step && (r_left != '0);
    assign ram_we    = (r_pend && ((r_kind == pol_pkg::KIND_INSERT)
                                || (r_kind == pol_pkg::KIND_REMOVE)))
                    || (ok_finish && (r_kind == pol_pkg::KIND_INSERT));
    assign ram_waddr = r_pend ? r_wr_addr : r_at;
    assign ram_wdata = r_pend ? ram_rdata : r_id;

    pol_ram #(
        .WIDTH (IW),
        .DEPTH (pol_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    assign o_sts.busy  = (r_left != '0) || r_pend;
    assign o_out_word  = r_out;

endmodule

/* rtl/pol_checker.sv */
`include "positional_ordered_list_macros.svh"

module pol_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input pol_pkg::t_in  i_in_word,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input pol_pkg::t_out o_out_word
);

    localparam int unsigned CNTW = pol_pkg::CNT_OUT_W;
    localparam int unsigned VALW = pol_pkg::SONG_W;

    logic held;
    logic take_in;
    logic out_full;
    logic out_empty;
    logic count_ok;
    logic full_ok;
    logic empty_ok;

    assign held      = o_out_valid && i_out_stall;
    assign take_in   = i_in_valid && !o_in_stall;
    assign out_full  = o_out_valid && (o_out_word.status == pol_pkg::ST_FULL);
    assign out_empty = o_out_valid && (o_out_word.status == pol_pkg::ST_EMPTY);
    assign count_ok  = (o_out_word.item_count <= CNTW'(pol_pkg::DEPTH));
    assign full_ok   = (o_out_word.item_count == CNTW'(pol_pkg::DEPTH)) && !o_out_word.hit;
    assign empty_ok  = (o_out_word.item_count == '0) && !o_out_word.hit
                    && (o_out_word.item_value == VALW'(0));

    `POL_ASSERT_NEXT(a_hold, held, o_out_valid && $stable(o_out_word), "stalled result moved")
    `POL_ASSERT_NEXT(a_busy_after_accept, take_in, o_in_stall, "command taken while busy")
    `POL_ASSERT_SAME(a_count_range, o_out_valid, count_ok, "item count above depth")
    `POL_ASSERT_SAME(a_full_count, out_full, full_ok, "full status with wrong count")
    `POL_ASSERT_SAME(a_empty_quiet, out_empty, empty_ok, "empty status with data")

endmodule

bind positional_ordered_list pol_checker u_pol_checker (.*);

/* bench/positional_ordered_list_tb.sv */
class ordered_list_tracker;
    logic [pol_pkg::SONG_W-1:0] ids [pol_pkg::DEPTH];
    int                         count           = 0;
    pol_pkg::t_out              pending_results [$];
    int                         mismatches      = 0;
    int                         results_checked = 0;
    int                         kind_seen [4]   = '{0, 0, 0, 0};
    int                         full_rejects    = 0;
    int                         empty_refusals  = 0;

    task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 40) begin
            $display("Mismatch in %s at %0t: expected %0h, got %0h", what, $time, want, got);
        end
    endtask

    task note_command(pol_pkg::t_in w);
        pol_pkg::t_out want;
        int            p;
        int            at;
        int            i;
        want        = '0;
        want.status = pol_pkg::ST_OK;
        p           = int'($signed(w.position));
        kind_seen[w.kind]++;
        if (w.kind == pol_pkg::KIND_INSERT) begin
            if (count >= pol_pkg::DEPTH) begin
                want.status = pol_pkg::ST_FULL;
                full_rejects++;
            end else begin
                at = (p < 0) ? 0 : ((p > count) ? count : p);
                for (i = count; i > at; i--) ids[i] = ids[i - 1];
                ids[at] = w.song_id;
                count++;
            end
        end else if (count == 0) begin
            want.status = pol_pkg::ST_EMPTY;
            empty_refusals++;
        end else begin
            at = ((p < 1) ? 1 : ((p > count) ? count : p)) - 1;
            case (w.kind)
                pol_pkg::KIND_REMOVE: begin
                    for (i = at; i + 1 < count; i++) ids[i] = ids[i + 1];
                    count--;
                end
                pol_pkg::KIND_READ: begin
                    want.item_value = ids[at];
                    want.hit        = 1'b1;
                end
                default: begin
                    for (i = 0; i < count; i++) begin
                        if (ids[i] == w.song_id) want.hit = 1'b1;
                    end
                end
            endcase
        end
        want.item_count = count[pol_pkg::CNT_OUT_W-1:0];
        pending_results.push_back(want);
    endtask

    task check_result(pol_pkg::t_out got);
        pol_pkg::t_out want;
        results_checked++;
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", 32'd0, 32'(got));
        end else begin
            want = pending_results.pop_front();
            if (got.item_value !== want.item_value) begin
                report_mismatch("item_value", 32'(want.item_value), 32'(got.item_value));
            end
            if (got.hit !== want.hit) begin
                report_mismatch("hit", 32'(want.hit), 32'(got.hit));
            end
            if (got.item_count !== want.item_count) begin
                report_mismatch("item_count", 32'(want.item_count), 32'(got.item_count));
            end
            if (got.status !== want.status) begin
                report_mismatch("status", 32'(want.status), 32'(got.status));
            end
        end
    endtask
endclass

module positional_ordered_list_tb;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 300;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_stall;
    pol_pkg::t_in   in_word   = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    pol_pkg::t_out  out_word;
    int             idle_pct  = 0;
    int             stall_pct = 0;
    int             cycles    = 0;

    ordered_list_tracker tracker = new();

    positional_ordered_list uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            tracker.check_result(out_word);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycles, tracker.pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic pol_pkg::t_in make_cmd(pol_pkg::t_kind k, logic [7:0] p,
                                              logic [15:0] id);
        pol_pkg::t_in w;
        w.kind     = k;
        w.position = p;
        w.song_id  = id;
        return w;
    endfunction

    function automatic pol_pkg::t_in random_command(bit growing);
        pol_pkg::t_in w;
        int           r;
        int           n;
        n = tracker.count;
        r = $urandom_range(0, 99);
        if (growing) begin
            w.kind = (r < 65) ? pol_pkg::KIND_INSERT : (r < 80) ? pol_pkg::KIND_REMOVE :
                     (r < 90) ? pol_pkg::KIND_READ : pol_pkg::KIND_CONTAINS;
        end else begin
            w.kind = (r < 10) ? pol_pkg::KIND_INSERT : (r < 70) ? pol_pkg::KIND_REMOVE :
                     (r < 85) ? pol_pkg::KIND_READ : pol_pkg::KIND_CONTAINS;
        end
        r = $urandom_range(0, 99);
        if (r < 10) begin
            w.position = 8'($urandom_range(0, 255));
        end else if (r < 25) begin
            case ($urandom_range(0, 3))
                0:       w.position = 8'hFF;
                1:       w.position = 8'd0;
                2:       w.position = 8'(n + 1);
                default: w.position = 8'd64;
            endcase
        end else begin
            w.position = 8'($urandom_range(0, n + 1));
        end
        if (n > 0 && $urandom_range(0, 99) < 40) begin
            w.song_id = tracker.ids[$urandom_range(0, n - 1)];
        end else begin
            w.song_id = 16'($urandom_range(0, 65535));
        end
        return w;
    endfunction

    task automatic send_command(pol_pkg::t_in w);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        tracker.note_command(w);
        @(negedge clk);
    endtask

    task automatic run_directed();
        send_command(make_cmd(pol_pkg::KIND_CONTAINS, 8'd0,   16'h0000));
        send_command(make_cmd(pol_pkg::KIND_REMOVE,   8'd1,   16'h0000));
        send_command(make_cmd(pol_pkg::KIND_READ,     8'd0,   16'h0000));
        send_command(make_cmd(pol_pkg::KIND_INSERT,   8'd64,  16'hFFFF));
        send_command(make_cmd(pol_pkg::KIND_INSERT,   8'hFF,  16'h0000));
        send_command(make_cmd(pol_pkg::KIND_INSERT,   8'h7F,  16'h8000));
        send_command(make_cmd(pol_pkg::KIND_INSERT,   8'h80,  16'h1234));
        send_command(make_cmd(pol_pkg::KIND_INSERT,   8'd2,   16'h00FF));
        send_command(make_cmd(pol_pkg::KIND_READ,     8'd0,   16'h0000));
        send_command(make_cmd(pol_pkg::KIND_READ,     8'hFF,  16'h0000));
        send_command(make_cmd(pol_pkg::KIND_READ,     8'd64,  16'h0000));
        send_command(make_cmd(pol_pkg::KIND_READ,     8'd3,   16'h0000));
        send_command(make_cmd(pol_pkg::KIND_CONTAINS, 8'd0,   16'hFFFF));
        send_command(make_cmd(pol_pkg::KIND_CONTAINS, 8'd0,   16'h5555));
        send_command(make_cmd(pol_pkg::KIND_REMOVE,   8'd0,   16'h0000));
        send_command(make_cmd(pol_pkg::KIND_REMOVE,   8'h7F,  16'h0000));
        send_command(make_cmd(pol_pkg::KIND_REMOVE,   8'h80,  16'h0000));
        send_command(make_cmd(pol_pkg::KIND_READ,     8'd1,   16'h0000));
        send_command(make_cmd(pol_pkg::KIND_REMOVE,   8'd1,   16'h0000));
        send_command(make_cmd(pol_pkg::KIND_REMOVE,   8'd1,   16'h0000));
        send_command(make_cmd(pol_pkg::KIND_READ,     8'd1,   16'h0000));
        send_command(make_cmd(pol_pkg::KIND_INSERT,   8'd1,   16'hAAAA));
        send_command(make_cmd(pol_pkg::KIND_CONTAINS, 8'hFF,  16'hAAAA));
    endtask

    initial begin
        int phase;
        int n;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        run_directed();
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 49; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 49; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_command(random_command(n < PHASE_ITEMS / 2));
            end
        end
        in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        $display("Ran %0d inserts (%0d refused on a full list), %0d removes, %0d reads.",
                 tracker.kind_seen[pol_pkg::KIND_INSERT], tracker.full_rejects,
                 tracker.kind_seen[pol_pkg::KIND_REMOVE], tracker.kind_seen[pol_pkg::KIND_READ]);
        $display("%0d lookups; %0d commands met an empty list; %0d results checked, %0d mismatches.",
                 tracker.kind_seen[pol_pkg::KIND_CONTAINS], tracker.empty_refusals,
                 tracker.results_checked, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/pol_pkg.sv
rtl/pol_ram.sv
rtl/pol_ctrl.sv
rtl/pol_datapath.sv
rtl/positional_ordered_list.sv
rtl/pol_checker.sv
bench/positional_ordered_list_tb.sv
